[rtl/form_body_field_parser_assert.svh]
`ifndef FORM_BODY_FIELD_PARSER_ASSERT_SVH
`define FORM_BODY_FIELD_PARSER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define FBFP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define FBFP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/fbfp_pkg.sv]
`timescale 1ns / 1ps

package fbfp_pkg;

	localparam int unsigned URL_MAX  = 255;
	localparam int unsigned CRED_MAX = 127;

	localparam logic [7:0] URL_CAP  = 8'(URL_MAX);
	localparam logic [7:0] CRED_CAP = 8'(CRED_MAX);

	localparam logic [1:0] FIELD_URL  = 2'd0;
	localparam logic [1:0] FIELD_SSID = 2'd1;
	localparam logic [1:0] FIELD_PASS = 2'd2;
	localparam logic [1:0] FIELD_NONE = 2'd3;

	localparam logic [1:0] ESC_IDLE = 2'd0;
	localparam logic [1:0] ESC_HIGH = 2'd1;
	localparam logic [1:0] ESC_LOW  = 2'd2;

	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TILDE = 8'h7E;

	localparam logic [2:0] KEY_COUNT_MAX = 3'd7;

	typedef struct packed {
		logic            in_value;
		logic [2:0]      key_count;
		logic [2:0]      key_match;
		logic [1:0]      active_field;
		logic [1:0]      escape_phase;
		logic [7:0]      escape_acc;
		logic [2:0][7:0] field_length;
		logic [2:0]      field_printable;
	} fbfp_state_t;

	localparam fbfp_state_t STATE_RESET = '{
		in_value:        1'b0,
		key_count:       3'd0,
		key_match:       3'b111,
		active_field:    FIELD_NONE,
		escape_phase:    ESC_IDLE,
		escape_acc:      8'd0,
		field_length:    '0,
		field_printable: 3'b000
	};

	typedef struct packed {
		logic       write_valid;
		logic [1:0] field_id;
		logic [7:0] char_pos;
		logic [7:0] char_value;
		logic       done_res;
		logic       status;
	} fbfp_res_t;

	function automatic logic [2:0] key_len(input logic [1:0] f);
		case (f)
			FIELD_URL: key_len = 3'd3;
			FIELD_SSID: key_len = 3'd4;
			FIELD_PASS: key_len = 3'd4;
			default: key_len = 3'd0;
		endcase
	endfunction

	function automatic logic [7:0] key_char(input logic [1:0] f, input logic [1:0] idx);
		key_char = 8'h00;
		case (f)
			FIELD_URL: begin
				case (idx)
					2'd0: key_char = 8'h75; // u
					2'd1: key_char = 8'h72; // r
					2'd2: key_char = 8'h6C; // l
					default: key_char = 8'h00;
				endcase
			end
			FIELD_SSID: begin
				case (idx)
					2'd0: key_char = 8'h73; // s
					2'd1: key_char = 8'h73; // s
					2'd2: key_char = 8'h69; // i
					default: key_char = 8'h64; // d
				endcase
			end
			FIELD_PASS: begin
				case (idx)
					2'd0: key_char = 8'h70; // p
					2'd1: key_char = 8'h61; // a
					2'd2: key_char = 8'h73; // s
					default: key_char = 8'h73; // s
				endcase
			end
			default: key_char = 8'h00;
		endcase
	endfunction

	// {valid, digit}
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		hex_digit = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			hex_digit = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			hex_digit = {1'b1, 4'(c - 8'h37)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			hex_digit = {1'b1, 4'(c - 8'h57)};
		end
	endfunction

endpackage

[rtl/fbfp_step.sv]
`timescale 1ns / 1ps

module fbfp_step (
	input  fbfp_pkg::fbfp_state_t cur,
	input  logic [7:0]            data_byte,
	input  logic                  body_end,
	output fbfp_pkg::fbfp_state_t nxt,
	output fbfp_pkg::fbfp_res_t   res,
	output logic                  res_valid
);
	import fbfp_pkg::*;

	logic       store_req;
	logic [7:0] store_v;
	logic [4:0] hx;
	logic [7:0] acc_n;
	logic [7:0] cap;
	logic       emit;
	logic [7:0] emit_pos;
	logic       bad;

	assign hx    = hex_digit(data_byte);
	assign acc_n = hx[4] ? {cur.escape_acc[3:0], hx[3:0]} : cur.escape_acc;
	assign cap   = (cur.active_field == FIELD_URL) ? URL_CAP : CRED_CAP;

	always_comb begin
		nxt       = cur;
		store_req = 1'b0;
		store_v   = data_byte;
		emit      = 1'b0;
		emit_pos  = 8'd0;
		bad       = 1'b0;

		if (data_byte == CH_AMP) begin
			// flush a cut-short escape, then restart the pair
			store_req        = cur.in_value && (cur.escape_phase != ESC_IDLE);
			store_v          = cur.escape_acc;
			nxt.in_value     = 1'b0;
			nxt.key_count    = 3'd0;
			nxt.key_match    = 3'b111;
			nxt.active_field = FIELD_NONE;
			nxt.escape_phase = ESC_IDLE;
			nxt.escape_acc   = 8'd0;
		end else if (!cur.in_value) begin
			if (data_byte == CH_EQ) begin
				nxt.active_field = FIELD_NONE;
				for (int i = 0; i < 3; i++) begin
					if (cur.key_match[i] && cur.key_count == key_len(2'(i))) begin
						nxt.active_field       = 2'(i);
						nxt.field_length[i]    = 8'd0;
						nxt.field_printable[i] = 1'b1;
					end
				end
				nxt.in_value = 1'b1;
			end else begin
				for (int i = 0; i < 3; i++) begin
					if (cur.key_count >= key_len(2'(i)) ||
					    key_char(2'(i), cur.key_count[1:0]) != data_byte) begin
						nxt.key_match[i] = 1'b0;
					end
				end
				if (cur.key_count != KEY_COUNT_MAX) begin
					nxt.key_count = cur.key_count + 3'd1;
				end
			end
		end else if (cur.active_field == FIELD_NONE) begin
			// unknown key: consume the value
		end else if (cur.active_field != FIELD_URL) begin
			store_req = 1'b1;
		end else if (cur.escape_phase != ESC_IDLE) begin
			if (cur.escape_phase == ESC_HIGH) begin
				nxt.escape_phase = ESC_LOW;
				nxt.escape_acc   = acc_n;
				store_req        = body_end;
				store_v          = acc_n;
			end else begin
				nxt.escape_phase = ESC_IDLE;
				nxt.escape_acc   = 8'd0;
				store_req        = 1'b1;
				store_v          = acc_n;
			end
		end else if (data_byte == CH_PCT) begin
			nxt.escape_phase = ESC_HIGH;
			nxt.escape_acc   = 8'd0;
		end else if (data_byte == CH_PLUS) begin
			store_req = 1'b1;
			store_v   = CH_SPACE;
		end else begin
			store_req = 1'b1;
		end

		for (int i = 0; i < 3; i++) begin
			if (store_req && store_v != 8'd0 && cur.active_field == 2'(i) &&
			    nxt.field_length[i] < cap) begin
				emit     = 1'b1;
				emit_pos = nxt.field_length[i];
				if (store_v < CH_SPACE || store_v > CH_TILDE) begin
					nxt.field_printable[i] = 1'b0;
				end
				nxt.field_length[i] = nxt.field_length[i] + 8'd1;
			end
		end

		for (int i = 0; i < 3; i++) begin
			if (!nxt.field_printable[i] || nxt.field_length[i] == 8'd0) begin
				bad = 1'b1;
			end
		end

		if (body_end) begin
			nxt = STATE_RESET;
		end
	end

	assign res_valid       = emit || body_end;
	assign res.write_valid = emit;
	assign res.field_id    = emit ? cur.active_field : FIELD_URL;
	assign res.char_pos    = emit ? emit_pos : 8'd0;
	assign res.char_value  = emit ? store_v : 8'd0;
	assign res.done_res    = body_end;
	assign res.status      = body_end && bad;

endmodule

[rtl/fbfp_out_reg.sv]
`timescale 1ns / 1ps

module fbfp_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  fbfp_pkg::fbfp_res_t res,
	output logic                free,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [23:0]         m_tdata,  // char_pos, char_value, status, zero pad
	output logic [2:0]          m_tuser,  // write_valid, field_id
	output logic                m_tlast   // done_res
);
	import fbfp_pkg::*;

	logic      valid_q;
	fbfp_res_t res_q;

	assign free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {7'd0, res_q.status, res_q.char_value, res_q.char_pos};
	assign m_tuser  = {res_q.field_id, res_q.write_valid};
	assign m_tlast  = res_q.done_res;

endmodule

[rtl/form_body_field_parser.sv]
`timescale 1ns / 1ps
// A body byte is held in byte_s1, then its word is registered in u_out for m_tvalid.
// One byte per cycle unless its word stalls; the parse state updates in one pass per byte.
// A byte with no result still advances even while the output word is stalled.
// Reset (arst_n low, asynchronous): parser idle, all three fields absent, no word pending.
// After the final byte of a body the parse state returns to its reset value by itself.

module form_body_field_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // data_byte
	input  logic        s_tlast,  // body_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // char_pos, char_value, status, zero pad
	output logic [2:0]  m_tuser,  // write_valid, field_id
	output logic        m_tlast   // done_res
);
	import fbfp_pkg::*;

	`include "form_body_field_parser_assert.svh"

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	fbfp_state_t state_q;
	fbfp_state_t state_n;
	fbfp_res_t   res;
	logic        res_valid;
	logic        out_free;
	logic        proc;

	assign proc     = valid_s1 && (out_free || !res_valid);
	assign s_tready = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (proc) begin
			state_q <= state_n;
		end
	end

	fbfp_step u_step (
		.cur       (state_q),
		.data_byte (byte_s1),
		.body_end  (last_s1),
		.nxt       (state_n),
		.res       (res),
		.res_valid (res_valid)
	);

	fbfp_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (proc && res_valid),
		.res      (res),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	`FBFP_ASSERT_NOW(a_field_known, m_tvalid && m_tuser[0], m_tuser[2:1] != FIELD_NONE, "write word names no field")
	`FBFP_ASSERT_NOW(a_cred_cap, m_tvalid && m_tuser[0] && m_tuser[2:1] != FIELD_URL, m_tdata[7:0] < CRED_CAP, "credential position past cap")
	`FBFP_ASSERT_NOW(a_no_zero_char, m_tvalid && m_tuser[0], m_tdata[15:8] != 8'd0, "zero character written")
	`FBFP_ASSERT_NOW(a_status_at_done, m_tvalid && m_tdata[16], m_tlast, "status set without done")
	`FBFP_ASSERT_NEXT(a_reset_after_end, proc && last_s1, !state_q.in_value && state_q.key_count == 3'd0 && state_q.field_printable == 3'b000, "state not cleared after body end")

endmodule
